[rtl/msp_ser_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MSP v1 frame serializer package
// Shared widths, frame constants and the controller-to-datapath command.
// ---------------------------------------------------------------------------
package msp_ser_pkg;

   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned VALUE_W          = 16;
   localparam int unsigned NUM_VALUE_FIELDS = 6;
   localparam int unsigned MAX_VALUES_DEF   = 6;

   // Value counter and value index widths cover the six value fields.
   localparam int unsigned CNT_W = $clog2(NUM_VALUE_FIELDS + 1);
   localparam int unsigned IDX_W = $clog2(NUM_VALUE_FIELDS);

   // Header is five bytes; the longest frame ends at position 5 + 2 * 6.
   localparam int unsigned HDR_LEN = 5;
   localparam int unsigned POS_W   = $clog2(HDR_LEN + 2 * NUM_VALUE_FIELDS + 1);

   localparam logic [BYTE_W-1:0] SYNC_ONE = 8'h24;
   localparam logic [BYTE_W-1:0] SYNC_TWO = 8'h4D;

   localparam logic [POS_W-1:0] POS_SYNC_ONE  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC_TWO  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DIRECTION = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SIZE      = POS_W'(3);
   localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(4);
   localparam logic [POS_W-1:0] POS_PAYLOAD   = POS_W'(HDR_LEN);

   typedef struct packed {
      logic             load;
      logic             advance;
      logic [POS_W-1:0] pos;
      logic             at_last;
   } dp_cmd_type;

endpackage

[rtl/msp_ser_ifs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MSP v1 frame serializer channels
// Message request channel and frame byte response channel.
// ---------------------------------------------------------------------------
interface msp_ser_req_if;
   logic                                       valid;
   logic                                       ready;
   logic        [msp_ser_pkg::BYTE_W-1:0]      direction;
   logic        [msp_ser_pkg::BYTE_W-1:0]      payload_size;
   logic        [msp_ser_pkg::BYTE_W-1:0]      msg_type;
   logic signed [msp_ser_pkg::VALUE_W-1:0]     value_a;
   logic signed [msp_ser_pkg::VALUE_W-1:0]     value_b;
   logic signed [msp_ser_pkg::VALUE_W-1:0]     value_c;
   logic signed [msp_ser_pkg::VALUE_W-1:0]     value_d;
   logic signed [msp_ser_pkg::VALUE_W-1:0]     value_e;
   logic signed [msp_ser_pkg::VALUE_W-1:0]     value_f;

   modport source (output valid, direction, payload_size, msg_type,
                   value_a, value_b, value_c, value_d, value_e, value_f,
                   input ready);
   modport sink   (input valid, direction, payload_size, msg_type,
                   value_a, value_b, value_c, value_d, value_e, value_f,
                   output ready);
endinterface

interface msp_ser_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [msp_ser_pkg::BYTE_W-1:0]   frame_byte;
   logic                             last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

[rtl/msp_ser_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MSP v1 frame serializer controller
// Accepts a message, counts the frame position and finds the final byte.
// ---------------------------------------------------------------------------
module msp_ser_ctrl #(
   parameter int unsigned MAX_VALUES = msp_ser_pkg::MAX_VALUES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [msp_ser_pkg::BYTE_W-1:0]     req_payload_size,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output msp_ser_pkg::dp_cmd_type            cmd
);
   import msp_ser_pkg::*;

   localparam int unsigned CAP =
      (MAX_VALUES > NUM_VALUE_FIELDS) ? NUM_VALUE_FIELDS : MAX_VALUES;

   localparam logic [0:0] STATE_IDLE = 1'b0;
   localparam logic [0:0] STATE_SEND = 1'b1;

   logic [0:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] last_pos_ff, last_pos_in;

   logic             req_xfer;
   logic             rsp_xfer;
   logic [6:0]       half_size;
   logic [CNT_W-1:0] num_values;
   logic             at_last;

   assign half_size  = req_payload_size[BYTE_W-1:1];
   assign num_values = (half_size > 7'(CAP)) ? CNT_W'(CAP) : half_size[CNT_W-1:0];

   assign req_ready = (state_ff == STATE_IDLE);
   assign rsp_valid = (state_ff == STATE_SEND);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign at_last   = (pos_ff == last_pos_ff);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      last_pos_in = last_pos_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_xfer) begin
               state_in    = STATE_SEND;
               pos_in      = POS_SYNC_ONE;
               last_pos_in = POS_PAYLOAD + POS_W'({num_values, 1'b0});
            end
         end
         STATE_SEND: begin
            if (rsp_xfer) begin
               if (at_last) begin
                  state_in = STATE_IDLE;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_IDLE;
         pos_ff      <= '0;
         last_pos_ff <= '0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         last_pos_ff <= last_pos_in;
      end
   end

   assign cmd.load    = req_xfer;
   assign cmd.advance = rsp_xfer;
   assign cmd.pos     = pos_ff;
   assign cmd.at_last = at_last;

endmodule

[rtl/msp_ser_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MSP v1 frame serializer datapath
// Holds the message, selects the frame byte and accumulates the checksum.
// ---------------------------------------------------------------------------
module msp_ser_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  msp_ser_pkg::dp_cmd_type               cmd,
   input  logic        [msp_ser_pkg::BYTE_W-1:0] req_direction,
   input  logic        [msp_ser_pkg::BYTE_W-1:0] req_payload_size,
   input  logic        [msp_ser_pkg::BYTE_W-1:0] req_msg_type,
   input  logic signed [msp_ser_pkg::VALUE_W-1:0] req_value_a,
   input  logic signed [msp_ser_pkg::VALUE_W-1:0] req_value_b,
   input  logic signed [msp_ser_pkg::VALUE_W-1:0] req_value_c,
   input  logic signed [msp_ser_pkg::VALUE_W-1:0] req_value_d,
   input  logic signed [msp_ser_pkg::VALUE_W-1:0] req_value_e,
   input  logic signed [msp_ser_pkg::VALUE_W-1:0] req_value_f,
   output logic        [msp_ser_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic                                  rsp_last_byte
);
   import msp_ser_pkg::*;

   logic [BYTE_W-1:0]  direction_ff;
   logic [BYTE_W-1:0]  size_ff;
   logic [BYTE_W-1:0]  type_ff;
   logic [VALUE_W-1:0] values_ff [NUM_VALUE_FIELDS];
   logic [BYTE_W-1:0]  checksum_ff, checksum_in;

   logic [POS_W-1:0]   payload_off;
   logic [IDX_W-1:0]   value_idx;
   logic [VALUE_W-1:0] value_sel;
   logic [BYTE_W-1:0]  payload_byte;
   logic               is_payload;

   assign payload_off  = cmd.pos - POS_PAYLOAD;
   assign value_idx    = payload_off[IDX_W:1];
   assign value_sel    = values_ff[value_idx];
   assign payload_byte = payload_off[0] ? value_sel[VALUE_W-1:BYTE_W]
                                        : value_sel[BYTE_W-1:0];
   assign is_payload   = (cmd.pos >= POS_PAYLOAD) && !cmd.at_last;

   always_comb begin
      unique case (cmd.pos)
         POS_SYNC_ONE:  rsp_frame_byte = SYNC_ONE;
         POS_SYNC_TWO:  rsp_frame_byte = SYNC_TWO;
         POS_DIRECTION: rsp_frame_byte = direction_ff;
         POS_SIZE:      rsp_frame_byte = size_ff;
         POS_TYPE:      rsp_frame_byte = type_ff;
         default:       rsp_frame_byte = cmd.at_last ? checksum_ff : payload_byte;
      endcase
   end

   assign rsp_last_byte = cmd.at_last;

   always_comb begin
      checksum_in = checksum_ff;
      if (cmd.load) begin
         checksum_in = req_payload_size ^ req_msg_type;
      end else if (cmd.advance && is_payload) begin
         checksum_in = checksum_ff ^ payload_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_ff <= '0;
      end else begin
         checksum_ff <= checksum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         direction_ff <= req_direction;
         size_ff      <= req_payload_size;
         type_ff      <= req_msg_type;
         values_ff[0] <= req_value_a;
         values_ff[1] <= req_value_b;
         values_ff[2] <= req_value_c;
         values_ff[3] <= req_value_d;
         values_ff[4] <= req_value_e;
         values_ff[5] <= req_value_f;
      end
   end

endmodule

[rtl/msp_v1_frame_serializer_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MSP v1 frame serializer core
// Turns one message into a framed MSP v1 byte stream with XOR checksum.
// ---------------------------------------------------------------------------
// One message is taken on the request channel while the block is idle, and
// its frame leaves on the response channel one byte per transfer: '$', 'M',
// direction, size, type, then min(size / 2, MAX_VALUES, 6) values low byte
// first, then the checksum byte flagged by last_byte. A frame is 6 to 18
// bytes; the position counter of the controller steps one byte per cycle
// while the sink is ready.
module msp_v1_frame_serializer_core #(
   parameter int unsigned MAX_VALUES = msp_ser_pkg::MAX_VALUES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   msp_ser_req_if.sink    req_chan,
   msp_ser_rsp_if.source  rsp_chan
);
   import msp_ser_pkg::*;

   dp_cmd_type cmd;

   msp_ser_ctrl #(
      .MAX_VALUES (MAX_VALUES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_payload_size (req_chan.payload_size),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .cmd              (cmd)
   );

   msp_ser_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_direction    (req_chan.direction),
      .req_payload_size (req_chan.payload_size),
      .req_msg_type     (req_chan.msg_type),
      .req_value_a      (req_chan.value_a),
      .req_value_b      (req_chan.value_b),
      .req_value_c      (req_chan.value_c),
      .req_value_d      (req_chan.value_d),
      .req_value_e      (req_chan.value_e),
      .req_value_f      (req_chan.value_f),
      .rsp_frame_byte   (rsp_chan.frame_byte),
      .rsp_last_byte    (rsp_chan.last_byte)
   );

   // A taken message starts its frame on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (rsp_chan.valid && cmd.pos == POS_SYNC_ONE))
      else $error("frame did not start after message transfer");

   // No new message is taken while a frame is being sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("message taken during a frame");

   // The frame ends after the transfer of its last byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_byte) |=> !rsp_chan.valid)
      else $error("frame continued past its last byte");

   // The first byte of every frame is the start marker.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && cmd.pos == POS_SYNC_ONE) |-> (rsp_chan.frame_byte == SYNC_ONE))
      else $error("frame does not open with the start marker");

endmodule
